[hdl/sed_pkg.sv]
// Shared types and constants of the string escape decoder.
`default_nettype none
package sed_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_OCT   = 3'd2,
		MODE_HEX0  = 3'd3,
		MODE_HEX1  = 3'd4,
		MODE_DONE  = 3'd5,
		MODE_ERR   = 3'd6
	} mode_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [8:0] OCT_MAX = 9'd255;

	typedef struct packed {
		mode_t      mode;
		logic [8:0] accum;
		logic [1:0] digit_count;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
		dec_state_t next;
	} dec_out_t;

endpackage
`default_nettype wire

[hdl/sed_decoder.sv]
// Combinational escape decode: one character and the current state in, results and next state out.
`default_nettype none
module sed_decoder (
	input  wire logic [7:0]         in_char,
	input  wire sed_pkg::dec_state_t state,
	output sed_pkg::dec_out_t       dec
);
	import sed_pkg::*;

	function automatic dec_out_t push(dec_out_t o, logic [7:0] data, logic [1:0] kind);
		dec_out_t r;
		r = o;
		if (o.count == 2'd0) begin
			r.res0.data = data;
			r.res0.kind = kind;
		end else begin
			r.res1.data = data;
			r.res1.kind = kind;
		end
		r.count = o.count + 2'd1;
		return r;
	endfunction

	// plain-state handling of a character, appended after any earlier result
	function automatic dec_out_t plain(dec_out_t o, logic [7:0] c);
		dec_out_t r;
		r = o;
		if (c == 8'h5C) begin
			r.next.mode = MODE_ESC;
		end else if (c == 8'h22 || c == 8'h00) begin
			r.next.mode = MODE_DONE;
			r = push(r, 8'h00, KIND_END);
		end else begin
			r.next.mode = MODE_PLAIN;
			r = push(r, c, KIND_BYTE);
		end
		return r;
	endfunction

	logic       is_oct;
	logic       is_hex;
	logic [3:0] hex_val;
	logic [8:0] oct_acc;
	logic [1:0] oct_cnt;

	always_comb begin
		is_oct = (in_char >= 8'h30) && (in_char <= 8'h37);
		is_hex = ((in_char >= 8'h30) && (in_char <= 8'h39)) ||
			((in_char >= 8'h61) && (in_char <= 8'h66)) ||
			((in_char >= 8'h41) && (in_char <= 8'h46));
		if (in_char >= 8'h61)
			hex_val = 4'(in_char - 8'h57);
		else if (in_char >= 8'h41)
			hex_val = 4'(in_char - 8'h37);
		else
			hex_val = in_char[3:0];
		oct_acc = {state.accum[5:0], in_char[2:0]};
		oct_cnt = state.digit_count + 2'd1;
	end

	always_comb begin
		dec = '0;
		dec.next = state;
		case (state.mode)
			MODE_PLAIN: begin
				dec = plain(dec, in_char);
			end
			MODE_ESC: begin
				dec.next.mode = MODE_PLAIN;
				if (in_char == 8'h73) begin
					dec = push(dec, 8'h20, KIND_BYTE);
				end else if (in_char == 8'h72) begin
					dec = push(dec, 8'd13, KIND_BYTE);
				end else if (in_char == 8'h6E) begin
					dec = push(dec, 8'd10, KIND_BYTE);
				end else if (in_char == 8'h74) begin
					dec = push(dec, 8'd9, KIND_BYTE);
				end else if (in_char == 8'h22 || in_char == 8'h27 || in_char == 8'h5C) begin
					dec = push(dec, in_char, KIND_BYTE);
				end else if (is_oct) begin
					dec.next.accum       = {6'd0, in_char[2:0]};
					dec.next.digit_count = 2'd1;
					dec.next.mode        = MODE_OCT;
				end else if (in_char == 8'h78) begin
					dec.next.accum = 9'd0;
					dec.next.mode  = MODE_HEX0;
				end else if (in_char == 8'h00) begin
					dec = push(dec, 8'h5C, KIND_BYTE);
					dec = push(dec, 8'h00, KIND_END);
					dec.next.mode = MODE_DONE;
				end else begin
					// unknown escape: pass the backslash and the character through
					dec = push(dec, 8'h5C, KIND_BYTE);
					dec = push(dec, in_char, KIND_BYTE);
				end
			end
			MODE_OCT: begin
				if (is_oct) begin
					dec.next.accum       = oct_acc;
					dec.next.digit_count = oct_cnt;
					if (oct_cnt == 2'd3) begin
						dec.next.digit_count = 2'd0;
						dec.next.accum       = 9'd0;
						if (oct_acc > OCT_MAX) begin
							dec.next.mode = MODE_ERR;
							dec = push(dec, 8'h00, KIND_ERROR);
						end else begin
							dec.next.mode = MODE_PLAIN;
							dec = push(dec, oct_acc[7:0], KIND_BYTE);
						end
					end
				end else begin
					dec = push(dec, state.accum[7:0], KIND_BYTE);
					dec.next.accum       = 9'd0;
					dec.next.digit_count = 2'd0;
					dec = plain(dec, in_char);
				end
			end
			MODE_HEX0: begin
				if (is_hex) begin
					dec.next.accum = {5'd0, hex_val};
					dec.next.mode  = MODE_HEX1;
				end else begin
					dec.next.mode = MODE_ERR;
					dec = push(dec, 8'h00, KIND_ERROR);
				end
			end
			MODE_HEX1: begin
				if (is_hex) begin
					dec = push(dec, {state.accum[3:0], hex_val}, KIND_BYTE);
					dec.next.accum = 9'd0;
					dec.next.mode  = MODE_PLAIN;
				end else begin
					dec = push(dec, state.accum[7:0], KIND_BYTE);
					dec.next.accum = 9'd0;
					dec = plain(dec, in_char);
				end
			end
			default: begin
				// ended, error and unused codes: drop the character
			end
		endcase
		if (dec.count == 2'd1)
			dec.res0.last = 1'b1;
		else if (dec.count == 2'd2)
			dec.res1.last = 1'b1;
	end

endmodule
`default_nettype wire

[hdl/string_escape_decoder_top.sv]
// Top level of the string escape decoder: state register, decode and output queue.
`default_nettype none
// The block takes one character of a string literal per request, starting after
// the opening quote, and returns the decoded bytes. An accepted character is
// decoded in the same cycle it is taken and its zero, one or two results are
// written into a four-entry output queue; the decode state (mode, octal/hex
// accumulator, digit count) advances at the same edge. A new request is taken
// every cycle while the queue has room for two more results. The output port
// drains one result per cycle while out_ready is high, and a character that
// gives two results (an unknown escape, a digit run closed by a character
// other than a backslash, a backslash followed by NUL) needs both drained.
// The first result of a request reaches the output in the cycle after the
// request is taken if the queue was empty. A quote or NUL in plain text ends the
// literal and an octal value over 255 or an x escape with no hex digit raises an
// error; both are sticky until reset, and later characters are taken and dropped.
module string_escape_decoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic            last_of_run
);
	import sed_pkg::*;

	dec_state_t state_q;
	dec_out_t   dec;

	result_t    fifo_q [4];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [2:0] count_q;

	logic       in_acc;
	logic       out_acc;
	logic [2:0] push_n;

	sed_decoder u_dec (
		.in_char (in_char),
		.state   (state_q),
		.dec     (dec)
	);

	// hold off requests unless a worst-case pair of results fits
	assign in_ready  = (count_q <= 3'd2);
	assign out_valid = (count_q != 3'd0);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign push_n    = in_acc ? {1'b0, dec.count} : 3'd0;

	assign out_byte    = fifo_q[head_q].data;
	assign kind        = fifo_q[head_q].kind;
	assign last_of_run = fifo_q[head_q].last;

	// decode state advances only on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_PLAIN;
			state_q.accum       <= 9'd0;
			state_q.digit_count <= 2'd0;
		end else if (in_acc) begin
			state_q <= dec.next;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 2'd0;
			tail_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			tail_q  <= tail_q + push_n[1:0];
			count_q <= count_q + push_n - {2'b00, out_acc};
			if (out_acc)
				head_q <= head_q + 2'd1;
		end
	end

	// queue payload: write the first result at the tail, the second after it
	always_ff @(posedge clk) begin
		if (in_acc && dec.count != 2'd0)
			fifo_q[tail_q] <= dec.res0;
		if (in_acc && dec.count == 2'd2)
			fifo_q[tail_q + 2'd1] <= dec.res1;
	end

endmodule
`default_nettype wire

[hdl/sed_checker.sv]
// Port-level assertions for the string escape decoder, bound to the top level.
`default_nettype none
module sed_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic [1:0] kind,
	input wire logic       last_of_run
);
	import sed_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(last_of_run))
		else $error("result changed while stalled");

	// end and error results carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> out_byte == 8'h00)
		else $error("nonzero byte on end or error result");

	// end and error results close the run of their character
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_END || kind == KIND_ERROR) |-> last_of_run)
		else $error("end or error result not last of run");

	// kind code three never appears
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 2'd3)
		else $error("undefined result kind");

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (.*);
`default_nettype wire

[tb/escape_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the string escape decoder: predicts the results of each request and compares.
module escape_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [1:0] kind,
	input  logic       last_of_run,
	output int         fail_count,
	output int         outstanding,
	output int         checked_count
);
	import sed_pkg::*;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	mode_t      dec_mode;
	logic [8:0] digit_acc;
	logic [1:0] oct_digits;
	result_t    staged [0:1];
	int         staged_n;
	result_t    decoded_q [$];
	result_t    want;
	int         fails;
	int         checked;

	function automatic logic is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_char_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "a")
			v = c - "a" + 8'd10;
		else if (c >= "A")
			v = c - "A" + 8'd10;
		else
			v = c - "0";
		return v[3:0];
	endfunction

	function void stage(input logic [7:0] data, input logic [1:0] k);
		staged[staged_n] = '{data: data, kind: k, last: 1'b0};
		staged_n++;
	endfunction

	function void take_plain(input logic [7:0] c);
		if (c == CH_BSLASH) begin
			dec_mode = MODE_ESC;
		end else if (c == CH_DQUOTE || c == CH_NUL) begin
			dec_mode = MODE_DONE;
			stage(8'h00, KIND_END);
		end else begin
			dec_mode = MODE_PLAIN;
			stage(c, KIND_BYTE);
		end
	endfunction

	// Advance the decode state by one character and queue what it yields.
	function void decode_request(input logic [7:0] c);
		int i;
		staged_n = 0;
		case (dec_mode)
		MODE_PLAIN: begin
			take_plain(c);
		end
		MODE_ESC: begin
			dec_mode = MODE_PLAIN;
			if (c == "s") begin
				stage(CH_SPACE, KIND_BYTE);
			end else if (c == "r") begin
				stage(CH_CR, KIND_BYTE);
			end else if (c == "n") begin
				stage(CH_LF, KIND_BYTE);
			end else if (c == "t") begin
				stage(CH_TAB, KIND_BYTE);
			end else if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH) begin
				stage(c, KIND_BYTE);
			end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
				digit_acc = {6'd0, c[2:0]};
				oct_digits = 2'd1;
				dec_mode = MODE_OCT;
			end else if (c == "x") begin
				digit_acc = '0;
				dec_mode = MODE_HEX0;
			end else if (c == CH_NUL) begin
				stage(CH_BSLASH, KIND_BYTE);
				stage(8'h00, KIND_END);
				dec_mode = MODE_DONE;
			end else begin
				stage(CH_BSLASH, KIND_BYTE);
				stage(c, KIND_BYTE);
			end
		end
		MODE_OCT: begin
			if (c >= CH_ZERO && c <= CH_SEVEN) begin
				digit_acc = {digit_acc[5:0], c[2:0]};
				oct_digits = oct_digits + 2'd1;
				if (oct_digits == 2'd3) begin
					oct_digits = '0;
					if (digit_acc > OCT_MAX) begin
						dec_mode = MODE_ERR;
						stage(8'h00, KIND_ERROR);
					end else begin
						dec_mode = MODE_PLAIN;
						stage(digit_acc[7:0], KIND_BYTE);
					end
					digit_acc = '0;
				end
			end else begin
				stage(digit_acc[7:0], KIND_BYTE);
				digit_acc = '0;
				oct_digits = '0;
				take_plain(c);
			end
		end
		MODE_HEX0: begin
			if (is_hex_char(c)) begin
				digit_acc = {5'd0, hex_char_nibble(c)};
				dec_mode = MODE_HEX1;
			end else begin
				dec_mode = MODE_ERR;
				stage(8'h00, KIND_ERROR);
			end
		end
		MODE_HEX1: begin
			if (is_hex_char(c)) begin
				stage({digit_acc[3:0], hex_char_nibble(c)}, KIND_BYTE);
				digit_acc = '0;
				dec_mode = MODE_PLAIN;
			end else begin
				stage(digit_acc[7:0], KIND_BYTE);
				digit_acc = '0;
				take_plain(c);
			end
		end
		default: begin
			// ended or errored: drop the character
		end
		endcase
		if (staged_n > 0)
			staged[staged_n - 1].last = 1'b1;
		for (i = 0; i < staged_n; i++)
			decoded_q.push_back(staged[i]);
	endfunction

	function void check_field(input string field, input logic [7:0] got, input logic [7:0] exp_v);
		if (got !== exp_v) begin
			$display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
				$time, field, checked, exp_v, got);
			fails++;
		end
	endfunction

	// Compare first: a result leaving now can never come from a request taken at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_mode = MODE_PLAIN;
			digit_acc = '0;
			oct_digits = '0;
			decoded_q.delete();
			fails = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual byte %0h kind %0d last %0b",
						$time, out_byte, kind, last_of_run);
					fails++;
				end else begin
					want = decoded_q.pop_front();
					checked++;
					check_field("out_byte", out_byte, want.data);
					check_field("kind", {6'd0, kind}, {6'd0, want.kind});
					check_field("last_of_run", {7'd0, last_of_run}, {7'd0, want.last});
				end
			end
			if (in_valid && in_ready)
				decode_request(in_char);
		end
		fail_count <= fails;
		outstanding <= decoded_q.size();
		checked_count <= checked;
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench top: feeds one long string literal to the escape decoder and reports the verdict.
module testbench;
	import sed_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int OPENING_LEN   = 24;
	localparam int RANDOM_CHARS  = 1000;
	localparam int IGNORED_CHARS = 16;
	// Hold the result side off once, long enough to fill the four-entry queue
	// and push back on the character side.
	localparam int STALL_AT      = 120;
	localparam int STALL_CYCLES  = 300;
	// Drain time after the last expected result, to catch stray results.
	localparam int DRAIN_CYCLES  = 16;
	// Longest quiet stretch of a healthy run is the one long stall; every other
	// wait comes from the random gaps of either side. Allow several times the stall.
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum int {
		TOK_PLAIN,
		TOK_SIMPLE_ESC,
		TOK_OCTAL,
		TOK_HEX,
		TOK_UNKNOWN_ESC,
		TOK_HIGH_BYTE
	} token_t;

	// The ended and error modes are sticky and reset comes only once, so each
	// run closes the literal exactly one way, picked at random.
	typedef enum int {
		CLOSE_QUOTE,
		CLOSE_NUL,
		CLOSE_BSLASH_NUL,
		CLOSE_OCT_OVERFLOW,
		CLOSE_HEX_EMPTY,
		CLOSE_OCT_THEN_QUOTE,
		CLOSE_HEX_THEN_NUL
	} closer_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_char;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last_of_run;

	int fail_count;
	int outstanding;
	int checked_count;

	int         sent;
	int         idle_cycles;
	// Track an octal escape left open, so that plain digits that follow never
	// push a three-digit run over 255 before the chosen closing.
	int         oct_open_len;
	int         oct_lead;
	string      closer_name;
	logic [7:0] opening_chars [0:OPENING_LEN-1];

	string_escape_decoder_top u_dut (.*);

	escape_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Offer one request, idle first for a drawn number of cycles (none in stretches
	// with no idling), then hold valid and the character until the handshake.
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (((sent / 64) % 4) == 3)
			gap = 0;
		else
			gap = $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	function automatic logic [7:0] pick_hex_char();
		int idx;
		idx = $urandom_range(0, 21);
		if (idx < 10)
			return 8'(CH_ZERO + idx);
		else if (idx < 16)
			return 8'("a" + (idx - 10));
		else
			return 8'("A" + (idx - 16));
	endfunction

	function automatic logic is_escape_letter(input logic [7:0] c);
		return c == "s" || c == "r" || c == "n" || c == "t" || c == "x" ||
			c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH ||
			(c >= "0" && c <= "7");
	endfunction

	// Send one well-formed piece of literal text with random content.
	task automatic send_token();
		int         pick;
		int         len;
		int         first;
		int         i;
		token_t     tok;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			tok = TOK_PLAIN;
		else if (pick < 55)
			tok = TOK_SIMPLE_ESC;
		else if (pick < 70)
			tok = TOK_OCTAL;
		else if (pick < 82)
			tok = TOK_HEX;
		else if (pick < 94)
			tok = TOK_UNKNOWN_ESC;
		else
			tok = TOK_HIGH_BYTE;

		case (tok)
		TOK_PLAIN: begin
			do
				c = 8'($urandom_range(1, 127));
			while (c == CH_BSLASH || c == CH_DQUOTE);
			if (oct_open_len > 0 && c >= "0" && c <= "7") begin
				// a digit here extends the open octal run: allow only if safe
				if (oct_lead >= 4)
					c = c + 8'd8;
				else
					oct_open_len = (oct_open_len == 2) ? 0 : oct_open_len + 1;
			end else begin
				oct_open_len = 0;
			end
			send_char(c);
		end
		TOK_HIGH_BYTE: begin
			oct_open_len = 0;
			send_char(8'($urandom_range(128, 255)));
		end
		TOK_SIMPLE_ESC: begin
			oct_open_len = 0;
			send_char(CH_BSLASH);
			case ($urandom_range(0, 6))
			0: send_char("s");
			1: send_char("r");
			2: send_char("n");
			3: send_char("t");
			4: send_char(CH_DQUOTE);
			5: send_char(CH_SQUOTE);
			default: send_char(CH_BSLASH);
			endcase
		end
		TOK_OCTAL: begin
			len = $urandom_range(1, 3);
			first = (len == 3) ? $urandom_range(0, 3) : $urandom_range(0, 7);
			send_char(CH_BSLASH);
			send_char(8'(CH_ZERO + first));
			for (i = 1; i < len; i++)
				send_char(8'(CH_ZERO + $urandom_range(0, 7)));
			oct_open_len = (len < 3) ? len : 0;
			oct_lead = first;
		end
		TOK_HEX: begin
			oct_open_len = 0;
			send_char(CH_BSLASH);
			send_char("x");
			send_char(pick_hex_char());
			if ($urandom_range(0, 1) == 1)
				send_char(pick_hex_char());
		end
		default: begin
			oct_open_len = 0;
			do
				c = 8'($urandom_range(1, 255));
			while (is_escape_letter(c));
			send_char(CH_BSLASH);
			send_char(c);
		end
		endcase
	endtask

	// Receiver: drop ready for a drawn number of cycles before each result,
	// run stretches with no idling, and hold off once for a long stall.
	initial begin : result_side
		int gap;
		int taken;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == STALL_AT)
				gap = STALL_CYCLES;
			else if (((taken / 48) % 4) == 2)
				gap = 0;
			else
				gap = $urandom_range(0, 8);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	// Watchdog: count cycles in which neither channel completes a handshake.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, nothing moved for %0d cycles, %0d results outstanding",
				$time, idle_cycles, outstanding);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int         i;
		closer_t    closer;
		logic [7:0] c;
		sent = 0;
		oct_open_len = 0;
		oct_lead = 0;
		closer_name = "";
		// Directed opening: top octal byte, a short octal run closed by a new
		// escape, both hex digit cases, a hex run closed by plain text, digit 8
		// as an unknown escape, escaped backslash and quote, extreme plain bytes.
		opening_chars = '{
			CH_BSLASH, "3", "7", "7",
			CH_BSLASH, "7", CH_BSLASH, "r",
			CH_BSLASH, "x", "f", "F",
			CH_BSLASH, "x", "a", "n",
			CH_BSLASH, "8",
			CH_BSLASH, CH_BSLASH,
			8'hFF, 8'h01,
			CH_BSLASH, CH_SQUOTE
		};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_char <= 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < OPENING_LEN; i++)
			send_char(opening_chars[i]);

		while (sent < OPENING_LEN + RANDOM_CHARS)
			send_token();

		// Close the literal; the block goes sticky from here on.
		closer = closer_t'($urandom_range(0, 6));
		closer_name = closer.name();
		case (closer)
		CLOSE_QUOTE: begin
			send_char(CH_DQUOTE);
		end
		CLOSE_NUL: begin
			send_char(CH_NUL);
		end
		CLOSE_BSLASH_NUL: begin
			send_char(CH_BSLASH);
			send_char(CH_NUL);
		end
		CLOSE_OCT_OVERFLOW: begin
			send_char(CH_BSLASH);
			send_char(8'(CH_ZERO + $urandom_range(4, 7)));
			send_char(8'(CH_ZERO + $urandom_range(0, 7)));
			send_char(8'(CH_ZERO + $urandom_range(0, 7)));
		end
		CLOSE_HEX_EMPTY: begin
			send_char(CH_BSLASH);
			send_char("x");
			c = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(8'h67, 8'hFF));
			send_char(c);
		end
		CLOSE_OCT_THEN_QUOTE: begin
			send_char(CH_BSLASH);
			send_char(8'(CH_ZERO + $urandom_range(0, 7)));
			send_char(8'(CH_ZERO + $urandom_range(0, 7)));
			send_char(CH_DQUOTE);
		end
		default: begin
			send_char(CH_BSLASH);
			send_char("x");
			send_char(pick_hex_char());
			send_char(CH_NUL);
		end
		endcase

		// Anything after the close must be taken and dropped.
		for (i = 0; i < IGNORED_CHARS; i++)
			send_char(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d characters (%0d directed, %0d after the close), closed by %s.",
			sent, OPENING_LEN, IGNORED_CHARS, closer_name);
		$display("Compared %0d decoded results, with one %0d-cycle hold on the result side.",
			checked_count, STALL_CYCLES);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
